// File: sv/hrtv_pkg.sv
// Package: shared types, codes and helper functions for the request target validator.
package hrtv_pkg;

    localparam logic [1:0] KIND_PATH    = 2'd0;
    localparam logic [1:0] KIND_QUERY   = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_RAW_BAD   = 4'd1;
    localparam logic [3:0] ST_TRUNC     = 4'd2;
    localparam logic [3:0] ST_BAD_HEX   = 4'd3;
    localparam logic [3:0] ST_DEC_BAD   = 4'd4;
    localparam logic [3:0] ST_UTF8      = 4'd5;
    localparam logic [3:0] ST_NO_SLASH  = 4'd6;
    localparam logic [3:0] ST_DOT       = 4'd7;
    localparam logic [3:0] ST_DRIVE     = 4'd8;

    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    localparam logic [1:0] EERR_NONE  = 2'd0;
    localparam logic [1:0] EERR_TRUNC = 2'd1;
    localparam logic [1:0] EERR_HEX   = 2'd2;

    localparam logic [1:0] SERR_NONE  = 2'd0;
    localparam logic [1:0] SERR_DOT   = 2'd1;
    localparam logic [1:0] SERR_DRIVE = 2'd2;

    localparam logic [2:0] U8_NONE = 3'd0;
    localparam logic [2:0] U8_A0BF = 3'd1;
    localparam logic [2:0] U8_809F = 3'd2;
    localparam logic [2:0] U8_90BF = 3'd3;
    localparam logic [2:0] U8_808F = 3'd4;

    localparam int MAX_RES = 5;
    localparam int CNT_W   = 3;

    typedef struct packed {
        logic [7:0] target_byte;
        logic       has_byte;
        logic       end_of_target;
    } t_in_word;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] out_byte;
        logic [3:0] status;
        logic       slash_end;
        logic       end_of_result;
    } t_out_word;

    typedef struct packed {
        logic       in_query;
        logic [1:0] escape_phase;
        logic [7:0] high_nibble;
        logic       raw_forbidden_seen;
        logic [1:0] escape_error;
        logic       decoded_forbidden_seen;
        logic [1:0] utf8_bytes_left;
        logic [2:0] utf8_second_rule;
        logic       utf8_error_seen;
        logic       path_bytes_seen;
        logic       leading_slash_ok;
        logic [1:0] segment_length;
        logic [7:0] segment_first;
        logic [7:0] segment_second;
        logic [1:0] segment_error;
        logic       last_was_slash;
        logic       question_pending;
    } t_state;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
        return v;
    endfunction

    function automatic logic query_allowed(input logic [7:0] c);
        logic ok;
        ok = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39);
        case (c)
            8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h25, 8'h2F, 8'h3F, 8'h3A, 8'h40,
            8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C,
            8'h3B, 8'h3D: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

// File: sv/hrtv_if.sv
// Interface: valid/ready stream channel carrying one word.
interface hrtv_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/http_request_target_validator.sv
// Top level: HTTP request target percent-decoder, query encoder and validator.
//
//  channel  dir  word                                              results/word
//  i_in     in   target_byte, has_byte, end_of_target              -
//  o_out    out  item_kind, out_byte, status, slash_end, eor       0..5
//
// An input word is processed combinationally in one pass; its results
// (up to five) sit in a small result register and drain one per cycle while
// o_out.ready is high. A word that yields at most one result sustains one
// word per cycle; a %XX query byte holds input until its last result leaves.
// i_rst_n is synchronous, active low; it clears state and the result buffer.
// Output stalls hold input once the result buffer cannot take the next word.
module http_request_target_validator (
    input  logic i_clk,
    input  logic i_rst_n,
    hrtv_if.sink   i_in,
    hrtv_if.source o_out
);
    import hrtv_pkg::*;

    t_state r_st, n_st;
    t_out_word r_res [MAX_RES];
    t_out_word n_res [MAX_RES];
    logic [CNT_W-1:0] r_cnt, n_cnt, r_rd, n_rd;
    logic [CNT_W-1:0] cnt;
    t_in_word w;
    logic take, last_out;

    assign w        = i_in.data;
    assign last_out = o_out.valid && o_out.ready && (r_rd == r_cnt - 3'd1);
    // accept when empty or the last pending result leaves this cycle
    assign i_in.ready = (r_cnt == '0) || last_out;
    assign take       = i_in.valid && i_in.ready;
    assign o_out.valid = (r_cnt != '0);
    assign o_out.data  = r_res[r_rd];

    always_comb begin
        t_state s;
        logic [7:0] b, d;
        logic [4:0] h, l;
        logic endp, dopath;
        logic [1:0] code;
        logic [2:0] k;
        logic [7:0] lo, hi;
        logic [3:0] st;
        s = r_st;
        code = SERR_NONE;
        lo = 8'h80;
        hi = 8'hBF;
        st = ST_OK;
        cnt = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            n_res[i] = '0;
        end
        b = w.target_byte;
        d = b;
        dopath = 1'b0;
        h = hex_value(s.high_nibble);
        l = hex_value(b);
        if (w.has_byte) begin
            if (b == 8'h00 || b == 8'h5C || b == 8'h0D || b == 8'h0A)
                s.raw_forbidden_seen = 1'b1;
            if (s.in_query) begin
                if (s.question_pending) begin
                    n_res[cnt] = '{KIND_QUERY, 8'h3F, ST_OK, 1'b0, 1'b0};
                    cnt = cnt + 3'd1;
                    s.question_pending = 1'b0;
                end
                if (query_allowed(b)) begin
                    n_res[cnt] = '{KIND_QUERY, b, ST_OK, 1'b0, 1'b0};
                    cnt = cnt + 3'd1;
                end else begin
                    n_res[cnt] = '{KIND_QUERY, 8'h25, ST_OK, 1'b0, 1'b0};
                    n_res[cnt+3'd1] = '{KIND_QUERY, hex_digit(b[7:4]), ST_OK, 1'b0, 1'b0};
                    n_res[cnt+3'd2] = '{KIND_QUERY, hex_digit(b[3:0]), ST_OK, 1'b0, 1'b0};
                    cnt = cnt + 3'd3;
                end
            end else if (b == 8'h3F) begin
                s.question_pending = 1'b1;
            end else if (s.escape_phase == ESC_HIGH) begin
                s.high_nibble = b;
                s.escape_phase = ESC_LOW;
            end else if (s.escape_phase == ESC_LOW) begin
                s.escape_phase = ESC_IDLE;
                if (!h[4] && !l[4]) begin
                    d = {h[3:0], l[3:0]};
                    dopath = 1'b1;
                end else if (s.escape_error == EERR_NONE) begin
                    s.escape_error = EERR_HEX;
                end
            end else if (b == 8'h25) begin
                s.escape_phase = ESC_HIGH;
            end else begin
                dopath = 1'b1;
            end
        end
        if (dopath) begin
            if (d == 8'h00 || d == 8'h5C) s.decoded_forbidden_seen = 1'b1;
            // utf-8 tracking
            if (s.utf8_bytes_left == 2'd0) begin
                if (d >= 8'h80) begin
                    if (d >= 8'hC2 && d <= 8'hDF) begin
                        s.utf8_bytes_left = 2'd1; s.utf8_second_rule = U8_NONE;
                    end else if (d == 8'hE0) begin
                        s.utf8_bytes_left = 2'd2; s.utf8_second_rule = U8_A0BF;
                    end else if (d == 8'hED) begin
                        s.utf8_bytes_left = 2'd2; s.utf8_second_rule = U8_809F;
                    end else if (d >= 8'hE1 && d <= 8'hEF) begin
                        s.utf8_bytes_left = 2'd2; s.utf8_second_rule = U8_NONE;
                    end else if (d == 8'hF0) begin
                        s.utf8_bytes_left = 2'd3; s.utf8_second_rule = U8_90BF;
                    end else if (d >= 8'hF1 && d <= 8'hF3) begin
                        s.utf8_bytes_left = 2'd3; s.utf8_second_rule = U8_NONE;
                    end else if (d == 8'hF4) begin
                        s.utf8_bytes_left = 2'd3; s.utf8_second_rule = U8_808F;
                    end else begin
                        s.utf8_error_seen = 1'b1;
                    end
                end
            end else begin
                lo = (s.utf8_second_rule == U8_A0BF) ? 8'hA0 :
                     (s.utf8_second_rule == U8_90BF) ? 8'h90 : 8'h80;
                hi = (s.utf8_second_rule == U8_809F) ? 8'h9F :
                     (s.utf8_second_rule == U8_808F) ? 8'h8F : 8'hBF;
                s.utf8_second_rule = U8_NONE;
                if (d < lo || d > hi) begin
                    s.utf8_error_seen = 1'b1;
                    s.utf8_bytes_left = 2'd0;
                end else begin
                    s.utf8_bytes_left = s.utf8_bytes_left - 2'd1;
                end
            end
            // segment tracking
            if (!s.path_bytes_seen) begin
                s.path_bytes_seen = 1'b1;
                s.leading_slash_ok = (d == 8'h2F);
                s.segment_length = 2'd0;
            end else if (d == 8'h2F) begin
                code = SERR_NONE;
                if (s.segment_length == 2'd1 && s.segment_first == 8'h2E) code = SERR_DOT;
                else if (s.segment_length == 2'd2 && s.segment_first == 8'h2E &&
                         s.segment_second == 8'h2E) code = SERR_DOT;
                else if (s.segment_length >= 2'd2 && s.segment_second == 8'h3A &&
                         is_letter(s.segment_first)) code = SERR_DRIVE;
                if (code != SERR_NONE && s.segment_error == SERR_NONE) s.segment_error = code;
                s.segment_length = 2'd0;
            end else begin
                if (s.segment_length == 2'd0) s.segment_first = d;
                else if (s.segment_length == 2'd1) s.segment_second = d;
                if (s.segment_length != 2'd3) s.segment_length = s.segment_length + 2'd1;
            end
            s.last_was_slash = (d == 8'h2F);
            n_res[cnt] = '{KIND_PATH, d, ST_OK, 1'b0, 1'b0};
            cnt = cnt + 3'd1;
        end
        // path end: on '?' in the path, or at the end while still in path
        endp = (w.has_byte && !r_st.in_query && b == 8'h3F) ||
               (w.end_of_target && !s.in_query && !(w.has_byte && b == 8'h3F));
        if (endp) begin
            if (s.escape_phase != ESC_IDLE && s.escape_error == EERR_NONE)
                s.escape_error = EERR_TRUNC;
            s.escape_phase = ESC_IDLE;
            if (s.utf8_bytes_left != 2'd0) s.utf8_error_seen = 1'b1;
            s.utf8_bytes_left = 2'd0;
            s.utf8_second_rule = U8_NONE;
            if (s.path_bytes_seen) begin
                code = SERR_NONE;
                if (s.segment_length == 2'd1 && s.segment_first == 8'h2E) code = SERR_DOT;
                else if (s.segment_length == 2'd2 && s.segment_first == 8'h2E &&
                         s.segment_second == 8'h2E) code = SERR_DOT;
                else if (s.segment_length >= 2'd2 && s.segment_second == 8'h3A &&
                         is_letter(s.segment_first)) code = SERR_DRIVE;
                if (code != SERR_NONE && s.segment_error == SERR_NONE) s.segment_error = code;
                s.segment_length = 2'd0;
            end
        end
        if (w.has_byte && !r_st.in_query && b == 8'h3F) s.in_query = 1'b1;
        if (w.end_of_target) begin
            if (s.raw_forbidden_seen) st = ST_RAW_BAD;
            else if (s.escape_error == EERR_TRUNC) st = ST_TRUNC;
            else if (s.escape_error != EERR_NONE) st = ST_BAD_HEX;
            else if (s.decoded_forbidden_seen) st = ST_DEC_BAD;
            else if (s.utf8_error_seen) st = ST_UTF8;
            else if (!s.path_bytes_seen || !s.leading_slash_ok) st = ST_NO_SLASH;
            else if (s.segment_error == SERR_DOT) st = ST_DOT;
            else if (s.segment_error != SERR_NONE) st = ST_DRIVE;
            else st = ST_OK;
            n_res[cnt] = '{KIND_VERDICT, 8'h00, st,
                           (st == ST_OK) ? s.last_was_slash : 1'b0, 1'b0};
            cnt = cnt + 3'd1;
            s = '0;
        end
        for (int i = 0; i < MAX_RES; i++) begin
            k = 3'(i);
            if (k == cnt - 3'd1) n_res[i].end_of_result = 1'b1;
        end
        n_st = s;
    end

    always_comb begin
        n_cnt = r_cnt;
        n_rd  = r_rd;
        if (o_out.valid && o_out.ready) n_rd = r_rd + 3'd1;
        if (last_out) begin
            n_cnt = '0;
            n_rd  = '0;
        end
        if (take) begin
            n_cnt = cnt;
            n_rd  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= '0;
            r_cnt <= '0;
            r_rd  <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_rd  <= n_rd;
            if (take) r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int i = 0; i < MAX_RES; i++) begin
                r_res[i] <= n_res[i];
            end
        end
    end

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) || (r_rd < r_cnt)) else $error("read index past count");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(MAX_RES)) else $error("result count too large");
    a_last_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_out |-> o_out.data.end_of_result) else $error("last result unmarked");
    a_verdict_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && w.end_of_target) |=> (r_st == '0)) else $error("state kept after verdict");
endmodule
